FILE: rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types and constants shared by the Base64 stream decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // Default queue depths (entries); each must be at least 2.
    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    // Position of the next sextet within its group of four.
    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;
    localparam logic [1:0] PHASE_3 = 2'd3;

    // Input item: one raw character.
    typedef struct packed {
        logic [7:0] char_in;
        logic       stream_end;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_stream;
        logic       length_error;
    } out_item_t;

    // Classified character passed from front to back.
    typedef struct packed {
        logic [5:0] sextet;
        logic       in_alphabet;
        logic       last;
    } sym_t;

endpackage

FILE: rtl/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Small synchronous queue with push/full and pop/empty, head shown while
// not empty. Push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module b64d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = b64d_pkg::MID_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

FILE: rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Maps a raw character through the standard Base64 alphabet to a sextet and
// flags characters outside it ('=' included).
// ----------------------------------------------------------------------------
module b64d_front (
    input  b64d_pkg::in_item_t item,
    output b64d_pkg::sym_t     sym
);

    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    localparam logic [7:0] OFS_LO  = 8'd26;
    localparam logic [7:0] OFS_DIG = 8'd52;

    logic [7:0] ch;
    logic [7:0] val;

    assign ch = item.char_in;

    always_comb
    begin
        val             = '0;
        sym.in_alphabet = 1'b1;
        if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z)
        begin
            val = ch - CHAR_UP_A;
        end
        else if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z)
        begin
            val = ch - CHAR_LO_A + OFS_LO;
        end
        else if (ch >= CHAR_0 && ch <= CHAR_9)
        begin
            val = ch - CHAR_0 + OFS_DIG;
        end
        else if (ch == CHAR_PLUS)
        begin
            val = 8'd62;
        end
        else if (ch == CHAR_SLASH)
        begin
            val = 8'd63;
        end
        else
        begin
            sym.in_alphabet = 1'b0;
        end
        sym.sextet = val[5:0];
        sym.last   = item.stream_end;
    end

endmodule

FILE: rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Packs sextets into bytes, tracks the raw character count and builds the
// result items, including the end-of-stream result.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  b64d_pkg::sym_t      sym,
    input  logic                sym_empty,
    output logic                sym_pop,
    output b64d_pkg::out_item_t res,
    output logic                res_push,
    input  logic                res_full
);

    logic [1:0] phase_reg, phase_next;
    logic [7:0] partial_reg, partial_next;
    logic [1:0] raw_cnt_reg, raw_cnt_next;
    logic [1:0] raw_inc;
    logic       have_byte;
    logic [7:0] byte_val;
    logic       take;

    // A symbol is retired only when the result queue can take its result.
    assign take    = !sym_empty && !res_full;
    assign sym_pop = take;
    assign raw_inc = raw_cnt_reg + 2'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        partial_next = partial_reg;
        have_byte    = 1'b0;
        byte_val     = '0;
        if (sym.in_alphabet)
        begin
            phase_next = phase_reg + 2'd1;
            unique case (phase_reg)
                b64d_pkg::PHASE_0:
                begin
                    partial_next = {sym.sextet, 2'b00};
                end
                b64d_pkg::PHASE_1:
                begin
                    byte_val     = partial_reg | {6'd0, sym.sextet[5:4]};
                    partial_next = {sym.sextet[3:0], 4'd0};
                    have_byte    = 1'b1;
                end
                b64d_pkg::PHASE_2:
                begin
                    byte_val     = partial_reg | {4'd0, sym.sextet[5:2]};
                    partial_next = {sym.sextet[1:0], 6'd0};
                    have_byte    = 1'b1;
                end
                b64d_pkg::PHASE_3:
                begin
                    byte_val     = partial_reg | {2'd0, sym.sextet};
                    partial_next = '0;
                    have_byte    = 1'b1;
                end
                default:
                begin
                    partial_next = partial_reg;
                end
            endcase
        end
        raw_cnt_next = raw_inc;
        // End of stream starts a fresh stream
        if (sym.last)
        begin
            phase_next   = b64d_pkg::PHASE_0;
            partial_next = '0;
            raw_cnt_next = '0;
        end

        res.data_byte     = byte_val;
        res.byte_valid    = have_byte;
        res.end_of_stream = sym.last;
        res.length_error  = sym.last && (raw_inc != 2'd0);
        res_push          = take && (have_byte || sym.last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= b64d_pkg::PHASE_0;
            partial_reg <= '0;
            raw_cnt_reg <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            raw_cnt_reg <= raw_cnt_next;
        end
    end

endmodule

FILE: rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming Base64 (standard alphabet) decoder, one character per item.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------
//   input   | in        | push / full        | in_item  (char, end mark)
//   result  | out       | pop / empty        | out_item (byte, flags)
//
// One character per clock sustained while the result queue is not full; a
// character passes through the symbol queue, then the result queue. Characters
// that complete no byte and are not last produce no result. The symbol queue
// lets the front keep accepting while the result side stalls; full rises when
// the symbol queue is full. Reset clears queue pointers and the decode state.
// ----------------------------------------------------------------------------
module base64_stream_decoder #(
    parameter int MID_DEPTH = b64d_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = b64d_pkg::OUT_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  b64d_pkg::in_item_t  in_item,
    output logic                empty,
    input  logic                pop,
    output b64d_pkg::out_item_t out_item
);

    localparam int SYM_W = $bits(b64d_pkg::sym_t);
    localparam int RES_W = $bits(b64d_pkg::out_item_t);

    b64d_pkg::sym_t      sym_in;
    b64d_pkg::sym_t      sym_head;
    logic                sym_empty;
    logic                sym_pop;
    b64d_pkg::out_item_t res;
    logic                res_push;
    logic                res_full;

    b64d_front u_front (
        .item (in_item),
        .sym  (sym_in)
    );

    b64d_fifo #(
        .WIDTH (SYM_W),
        .DEPTH (MID_DEPTH)
    ) u_sym_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (sym_in),
        .full  (full),
        .pop   (sym_pop),
        .rdata (sym_head),
        .empty (sym_empty)
    );

    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym       (sym_head),
        .sym_empty (sym_empty),
        .sym_pop   (sym_pop),
        .res       (res),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    b64d_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_item),
        .empty (empty)
    );

endmodule

FILE: tb/sv/b64d_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64d_result_checker
// Watches both queue sides of the Base64 stream decoder, decodes every
// accepted character on its own copy of the group state, and compares each
// popped result field by field with the oldest decoded result still owed.
// ----------------------------------------------------------------------------
module b64d_result_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  b64d_pkg::in_item_t  in_item,
    input  logic                empty,
    input  logic                pop,
    input  b64d_pkg::out_item_t out_item,
    output int                  fail_count,
    output int                  pending_count
);
    import b64d_pkg::*;

    logic [1:0] phase_q;
    logic [7:0] partial_q;
    logic [1:0] raw_cnt_q;
    out_item_t  owed_results[$];
    int         errs = 0;
    int         owed = 0;

    assign fail_count    = errs;
    assign pending_count = owed;

    // bit 6 set: character is outside the alphabet
    function automatic logic [6:0] sextet_code(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z") return {1'b0, 6'(ch - "A")};
        if (ch >= "a" && ch <= "z") return {1'b0, 6'(ch - "a" + 26)};
        if (ch >= "0" && ch <= "9") return {1'b0, 6'(ch - "0" + 52)};
        if (ch == "+") return {1'b0, 6'd62};
        if (ch == "/") return {1'b0, 6'd63};
        return 7'h40;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t ns: %s: expected %0h, got %0h", $time, what, want, got);
        errs++;
    endtask

    task automatic decode_char(input in_item_t it);
        logic [6:0] code;
        logic [5:0] v;
        logic       made;
        out_item_t  res;
        code = sextet_code(it.char_in);
        v    = code[5:0];
        made = 1'b0;
        res  = '0;
        raw_cnt_q = raw_cnt_q + 2'd1;
        if (!code[6])
        begin
            case (phase_q)
                PHASE_0:
                begin
                    partial_q = {v, 2'b00};
                end
                PHASE_1:
                begin
                    res.data_byte = partial_q | {6'b0, v[5:4]};
                    partial_q     = {v[3:0], 4'b0};
                    made          = 1'b1;
                end
                PHASE_2:
                begin
                    res.data_byte = partial_q | {4'b0, v[5:2]};
                    partial_q     = {v[1:0], 6'b0};
                    made          = 1'b1;
                end
                default:
                begin
                    res.data_byte = partial_q | {2'b0, v};
                    partial_q     = '0;
                    made          = 1'b1;
                end
            endcase
            phase_q = phase_q + 2'd1;
        end
        if (made || it.stream_end)
        begin
            res.byte_valid    = made;
            res.end_of_stream = it.stream_end;
            res.length_error  = it.stream_end && (raw_cnt_q != 2'd0);
            owed_results.push_back(res);
        end
        // end of stream: next character opens a fresh stream
        if (it.stream_end)
        begin
            phase_q   = PHASE_0;
            partial_q = '0;
            raw_cnt_q = '0;
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (owed_results.size() == 0)
        begin
            report_mismatch("result with nothing owed", 8'h00, got.data_byte);
            return;
        end
        want = owed_results.pop_front();
        if (got.data_byte !== want.data_byte)
            report_mismatch("data_byte", want.data_byte, got.data_byte);
        if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
        if (got.end_of_stream !== want.end_of_stream)
            report_mismatch("end_of_stream", 8'(want.end_of_stream),
                            8'(got.end_of_stream));
        if (got.length_error !== want.length_error)
            report_mismatch("length_error", 8'(want.length_error),
                            8'(got.length_error));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_q   = PHASE_0;
            partial_q = '0;
            raw_cnt_q = '0;
            owed_results.delete();
            owed      = 0;
        end
        else
        begin
            if (pop && !empty)
                check_result(out_item);
            if (push && !full)
                decode_char(in_item);
            owed = owed_results.size();
        end
    end

endmodule

FILE: tb/sv/tb_base64_stream_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// Drives character streams into the Base64 stream decoder: a directed set
// covering the alphabet edges, padding, skipped bytes and bad lengths, then
// random well-formed, padded, noisy and truncated streams. Both sides idle in
// random bursts; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;
    import b64d_pkg::*;

    localparam int N_ITEMS     = 1600;
    localparam int HOLD_AT     = 400;
    localparam int DRAIN_AT    = 800;
    localparam int TAIL_AT     = 1450;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_CYCLES  = 200000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  in_item;
    logic      empty;
    logic      pop;
    out_item_t out_item;
    int        fail_count;
    int        pending_count;
    int        items_sent = 0;
    int        cycles = 0;
    bit        quiet_tail = 1'b0;
    bit        drained_once = 1'b0;

    base64_stream_decoder u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

    b64d_result_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .in_item       (in_item),
        .empty         (empty),
        .pop           (pop),
        .out_item      (out_item),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("tb_base64_stream_decoder: errors");
            $finish;
        end
    end

    function automatic logic [7:0] alpha_char(input int v);
        if (v < 26) return 8'("A" + v);
        if (v < 52) return 8'("a" + v - 26);
        if (v < 62) return 8'("0" + v - 52);
        if (v == 62) return "+";
        return "/";
    endfunction

    task automatic wait_drained();
        do @(negedge clk); while (pending_count != 0);
    endtask

    // push stays high across back-to-back items; it only drops for a gap
    task automatic send_char(input logic [7:0] ch, input logic last_char);
        in_item_t it;
        it.char_in    = ch;
        it.stream_end = last_char;
        push    <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (full) @(posedge clk);
        items_sent++;
        if (items_sent >= TAIL_AT)
            quiet_tail = 1'b1;
        if (!drained_once && items_sent >= DRAIN_AT) begin
            drained_once = 1'b1;
            push <= 1'b0;
            wait_drained();
            @(posedge clk);
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s, input logic end_on_last);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], end_on_last && (i == s.len() - 1));
    endtask

    task automatic send_stream();
        logic [7:0] chars[$];
        int         groups;
        int         kind;
        bit         noisy;
        groups = $urandom_range(1, 6);
        kind   = $urandom_range(0, 9);
        noisy  = (kind == 3);
        for (int i = 0; i < groups * 4; i++)
            chars.push_back(alpha_char($urandom_range(0, 63)));
        if (kind < 3) begin
            // padded tail
            for (int k = 0; k < $urandom_range(1, 2); k++)
                chars[chars.size() - 1 - k] = "=";
        end else if (kind == 4) begin
            // truncated: length no longer a multiple of four
            repeat ($urandom_range(1, 3)) void'(chars.pop_back());
        end
        for (int i = 0; i < chars.size(); i++) begin
            if (noisy && $urandom_range(0, 5) == 0)
                send_char(8'($urandom_range(0, 255)), 1'b0);
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        in_item = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // alphabet edges, then a stream ending on a pad character
        send_text("AZaz09+/", 1'b0);
        send_text("TWE=", 1'b1);
        // skipped bytes count toward length; last char completes a byte
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("QQ", 1'b1);
        // lone character: length error, no byte
        send_text("x", 1'b1);
        send_text("////", 1'b1);
        send_text("TWFu", 1'b1);

        while (items_sent < N_ITEMS) begin
            if ($urandom_range(0, 9) < 8)
                send_stream();
            else
                repeat ($urandom_range(1, 10))
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        end
        push <= 1'b0;

        wait_drained();
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("tb_base64_stream_decoder: clean");
        else
            $display("tb_base64_stream_decoder: errors");
        $finish;
    end

    // result side: random idle bursts, one long hold to back the block up
    initial
    begin
        int idle_left;
        int hold_left;
        bit held;
        idle_left = 0;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else if (!held && items_sent >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                pop <= 1'b0;
            end else if (idle_left > 0) begin
                pop <= 1'b0;
                idle_left--;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                idle_left = $urandom_range(1, 12) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

endmodule

FILE: files.f
rtl/b64d_pkg.sv
rtl/b64d_fifo.sv
rtl/b64d_front.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
tb/sv/b64d_result_checker.sv
tb/sv/tb_base64_stream_decoder.sv
